/* sv/rot13_line_wrap_filter_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text filter unit
// Immediate-implication and next-cycle-implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef ROT13_LINE_WRAP_FILTER_UNIT_MACROS_SVH
`define ROT13_LINE_WRAP_FILTER_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define RLW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlw assertion failed");

`else

`define RLW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RLW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/rlw_pkg.sv */
// ----------------------------------------------------------------------------
// rlw_pkg
// Types, constants and helper functions of the text filter unit.
// ----------------------------------------------------------------------------
package rlw_pkg;

    localparam int COLUMN_BITS_DEF = 8;
    localparam int LINE_BITS_DEF   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT13_ENABLE = 2'd2;

    localparam logic [7:0]  WRAP_WIDTH_RST = 8'd72;
    localparam logic [15:0] HEAD_LIMIT_RST = 16'd0;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UM = 8'h4D;
    localparam logic [7:0] CH_UN = 8'h4E;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LM = 8'h6D;
    localparam logic [7:0] CH_LN = 8'h6E;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] ROT_STEP = 8'd13;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_mark;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    function automatic logic [7:0] rotate_letter(input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        if ((ch >= CH_UA && ch <= CH_UM) || (ch >= CH_LA && ch <= CH_LM)) begin
            res = ch + ROT_STEP;
        end else if ((ch >= CH_UN && ch <= CH_UZ) || (ch >= CH_LN && ch <= CH_LZ)) begin
            res = ch - ROT_STEP;
        end
        return res;
    endfunction

endpackage

/* sv/rlw_chan_if.sv */
// ----------------------------------------------------------------------------
// rlw_chan_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface rlw_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/rot13_line_wrap_filter_unit.sv */
// ----------------------------------------------------------------------------
// rot13_line_wrap_filter_unit
// Text filter: drops carriage returns, optional ROT13, line wrap, head limit.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one text byte per request with an end_mark flag. o_out
//   carries emitted bytes; run_last marks the final byte caused by one input
//   request. An input request causes zero, one or two output requests.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle.
// Path: an accepted request is held in an input register, is processed from
//   there into a four-entry output queue once the queue has room for two
//   results, and is presented on o_out from the head of that queue.
// Throughput: one input request per cycle while o_out takes every result and
//   each causes at most one result; a request that inserts a wrap newline
//   is slowed by the single output port draining one result per cycle.
// Reset: the registers return to width 72, no head limit, ROT13 off; the
//   column and line counters clear and the output queue empties.
// Stall: while o_out is held off, results collect in the output queue; input
//   requests are taken until it cannot hold two more results and the input register is full.
// ----------------------------------------------------------------------------
`include "rot13_line_wrap_filter_unit_macros.svh"

module rot13_line_wrap_filter_unit #(
    parameter int COLUMN_BITS = rlw_pkg::COLUMN_BITS_DEF,
    parameter int LINE_BITS   = rlw_pkg::LINE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlw_chan_if.sink                        i_in,
    rlw_chan_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [rlw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rlw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int CMP_COL_W = (COLUMN_BITS > 8) ? COLUMN_BITS : 8;
    localparam int CMP_LIN_W = (LINE_BITS > 16) ? LINE_BITS : 16;

    // Configuration registers.
    logic [7:0]  r_wrap_width;
    logic [15:0] r_head_limit;
    logic        r_rot_en;

    // Input register.
    logic              r_in_valid;
    rlw_pkg::t_in_item r_in;

    // Filter state.
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic                   r_stopped, n_stopped;
    logic                   r_prev_nl, n_prev_nl;

    // Output queue.
    rlw_pkg::t_out_item r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               proc_fire;
    logic               pop;
    logic [1:0]         push_cnt;
    rlw_pkg::t_out_item push0, push1;
    logic [7:0]         ch;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic               wrap_hit;
    logic               head_hit;

    assign proc_fire   = r_in_valid && (r_count <= CNT_W'(OUT_DEPTH - 2));
    assign i_in.ready  = !r_in_valid || proc_fire;
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_fifo[r_rd_ptr];
    assign pop         = o_out.valid && o_out.ready;

    assign ch       = r_rot_en ? rlw_pkg::rotate_letter(r_in.in_byte) : r_in.in_byte;
    assign col_inc  = r_col + COLUMN_BITS'(1);
    assign line_inc = (r_line != '1) ? (r_line + LINE_BITS'(1)) : r_line;
    assign wrap_hit = (r_wrap_width != 8'd0) &&
                      (CMP_COL_W'(col_inc) >= CMP_COL_W'(r_wrap_width));
    assign head_hit = (r_head_limit != 16'd0) &&
                      (CMP_LIN_W'(line_inc) >= CMP_LIN_W'(r_head_limit));

    always_comb begin
        n_col     = r_col;
        n_line    = r_line;
        n_stopped = r_stopped;
        n_prev_nl = r_prev_nl;
        push_cnt  = 2'd0;
        push0     = '{out_byte: ch, run_last: 1'b1};
        push1     = '{out_byte: rlw_pkg::CH_LF, run_last: 1'b1};
        if (r_in.end_mark) begin
            if (!r_prev_nl) begin
                push0    = '{out_byte: rlw_pkg::CH_LF, run_last: 1'b1};
                push_cnt = 2'd1;
            end
            n_col     = '0;
            n_line    = '0;
            n_stopped = 1'b0;
            n_prev_nl = 1'b0;
        end else if (!r_stopped && r_in.in_byte != rlw_pkg::CH_CR) begin
            if (ch == rlw_pkg::CH_LF) begin
                n_col    = '0;
                n_line   = line_inc;
                push_cnt = 2'd1;
                // The stopping newline leaves the previous-newline flag untouched.
                if (head_hit) begin
                    n_stopped = 1'b1;
                end else begin
                    n_prev_nl = 1'b1;
                end
            end else begin
                n_prev_nl = 1'b0;
                if (wrap_hit) begin
                    n_col    = '0;
                    push0    = '{out_byte: ch, run_last: 1'b0};
                    push_cnt = 2'd2;
                end else begin
                    n_col    = col_inc;
                    push_cnt = 2'd1;
                end
            end
        end
        if (!proc_fire) begin
            n_col     = r_col;
            n_line    = r_line;
            n_stopped = r_stopped;
            n_prev_nl = r_prev_nl;
            push_cnt  = 2'd0;
        end
        n_count = r_count + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width <= rlw_pkg::WRAP_WIDTH_RST;
            r_head_limit <= rlw_pkg::HEAD_LIMIT_RST;
            r_rot_en     <= 1'b0;
            r_in_valid   <= 1'b0;
            r_col        <= '0;
            r_line       <= '0;
            r_stopped    <= 1'b0;
            r_prev_nl    <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rlw_pkg::CFG_WRAP_WIDTH:   r_wrap_width <= i_cfg_data[7:0];
                    rlw_pkg::CFG_HEAD_LIMIT:   r_head_limit <= i_cfg_data[15:0];
                    rlw_pkg::CFG_ROT13_ENABLE: r_rot_en     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_col     <= n_col;
            r_line    <= n_line;
            r_stopped <= n_stopped;
            r_prev_nl <= n_prev_nl;
            r_wr_ptr  <= r_wr_ptr + PTR_W'(push_cnt);
            r_rd_ptr  <= r_rd_ptr + PTR_W'(pop);
            r_count   <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= push0;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= push1;
        end
    end

    `RLW_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(OUT_DEPTH))
    `RLW_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, proc_fire && r_in.end_mark, r_col == '0 && r_line == '0 && !r_stopped && !r_prev_nl)
    `RLW_ASSERT_SAME(a_stopped_drops, i_clk, i_rst_n, proc_fire && r_stopped && !r_in.end_mark, push_cnt == 2'd0)
    `RLW_ASSERT_SAME(a_wrap_pair, i_clk, i_rst_n, push_cnt == 2'd2, !push0.run_last && push1.out_byte == rlw_pkg::CH_LF && r_in_valid)

endmodule
